>>> sv/vpa_pkg.sv
package vpa_pkg;

    // Hole length after reset, in memory units.
    localparam logic [15:0] MEM_SIZE_RESET = 16'd1000;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_GRANT  = 2'd0,
        ST_QUEUED = 2'd1,
        ST_REJECT = 2'd2,
        ST_TICK   = 2'd3
    } t_status;

    // Placement policies; the unused code behaves as first fit.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [7:0] REG_MEM_SIZE = 8'd0;
    localparam logic [7:0] REG_FIT_MODE = 8'd1;

    // Request kinds carried on the input side.
    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // Verdict of the fit comparator on one segment.
    typedef struct packed {
        logic take;
        logic stop;
    } t_fit;

endpackage

>>> sv/vpa_fit.sv
module vpa_fit (
    input  logic [1:0]   i_fit_mode,
    input  logic         i_used,
    input  logic [15:0]  i_len,
    input  logic [15:0]  i_size,
    input  logic         i_have,
    input  logic [15:0]  i_pick_len,
    output vpa_pkg::t_fit o_fit
);
    import vpa_pkg::*;

    logic fits;
    logic better;

    // A hole is a candidate when free and long enough; it replaces the
    // current pick only when strictly better, so ties keep the lower address.
    always_comb begin
        fits   = !i_used && (i_len >= i_size);
        better = !i_have
                 || ((i_fit_mode == FIT_BEST) && (i_len < i_pick_len))
                 || ((i_fit_mode == FIT_WORST) && (i_len > i_pick_len));
        o_fit.take = fits && better;
        o_fit.stop = fits && !i_have
                     && (i_fit_mode != FIT_BEST) && (i_fit_mode != FIT_WORST);
    end

endmodule

>>> sv/variable_partition_allocator.sv
// Channel   Direction  Handshake              Contents
// s         in         i_s_tvalid/o_s_tready  tdata: proc_id, req_size, run_time; tuser: action
// m         out        o_m_tvalid/i_m_tready  tdata: status, granted_id, base_address,
//                                             from_queue; tlast: last
// cfg       in         i_cfg_valid/o_cfg_ready index 0 mem_size, 1 fit_mode
//
// A request walks the segment table in address order, since the single fit
// comparator visits one segment a cycle.
// A tick releases and merges segments, then retries every waiting request,
// and each result word waits on the output until it has been taken.
// Reset is synchronous and active low; it leaves one free hole of 1000 units.
// One word is worked on at a time; input is refused until its last result
// has been taken, and a stalled result holds in the output register.
module variable_partition_allocator #(
    parameter int MAX_SEGMENTS = 32,
    parameter int WAIT_DEPTH   = 16,
    parameter int ADDR_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [7:0] proc_id, [23:8] req_size, [39:24] run_time
    input  logic        i_s_tuser,   // [0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [1:0] status, [9:2] granted_id,
                                     // [25:10] base_address, [26] from_queue
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import vpa_pkg::*;

    localparam int SI = $clog2(MAX_SEGMENTS);
    localparam int SC = $clog2(MAX_SEGMENTS + 1);
    localparam int WI = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WC = $clog2(WAIT_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_REL, S_MERGE, S_QSCAN, S_SCAN, S_DECIDE, S_OUT
    } t_state;

    // Segment table, address ordered.
    logic [ADDR_BITS-1:0] r_base [MAX_SEGMENTS];
    logic [15:0]          r_len  [MAX_SEGMENTS];
    logic [7:0]           r_own  [MAX_SEGMENTS];
    logic                 r_used [MAX_SEGMENTS];
    logic [31:0]          r_rel  [MAX_SEGMENTS];
    logic [SC-1:0]        r_cnt;

    // Wait queue, oldest first.
    logic [7:0]  r_wid  [WAIT_DEPTH];
    logic [15:0] r_wsz  [WAIT_DEPTH];
    logic [15:0] r_wrun [WAIT_DEPTH];
    logic [WC-1:0] r_wcnt;
    logic [WC-1:0] r_wi;

    logic [31:0]   r_time;
    logic [1:0]    r_fit;
    t_state        r_state;
    t_state        r_ret;
    logic [SC-1:0] r_idx;
    logic [SI-1:0] r_pick;
    logic [15:0]   r_plen;
    logic          r_have;
    logic [15:0]   r_acc;
    logic          r_prevfree;
    logic [7:0]    r_id;
    logic [15:0]   r_size;
    logic [15:0]   r_run;
    logic          r_fromq;

    logic          r_ovalid;
    t_status       r_ostat;
    logic [7:0]    r_oid;
    logic [15:0]   r_obase;
    logic          r_ofq;
    logic          r_olast;

    // Every single-entry table read goes through the one segment pointer; the shifts read neighbours directly.
    logic [SI-1:0]        rd;
    logic [ADDR_BITS-1:0] rd_base;
    logic [15:0]          rd_len;
    logic                 rd_used;
    logic [31:0]          rd_rel;
    logic [WI-1:0]        wrd;
    logic [15:0]          left;
    logic [ADDR_BITS-1:0] n_split_base;
    logic [31:0]          base_wide;
    logic [15:0]          in_size;
    logic [15:0]          in_run;
    t_fit                 fit;

    assign rd           = r_idx[SI-1:0];
    assign rd_base      = r_base[rd];
    assign rd_len       = r_len[rd];
    assign rd_used      = r_used[rd];
    assign rd_rel       = r_rel[rd];
    assign wrd          = r_wi[WI-1:0];
    assign left         = rd_len - r_size;
    assign n_split_base = rd_base + ADDR_BITS'(r_size);
    assign base_wide    = 32'(rd_base);
    // Zero size and zero run time are taken as one.
    assign in_size      = (i_s_tdata[23:8] == 16'd0) ? 16'd1 : i_s_tdata[23:8];
    assign in_run       = (i_s_tdata[39:24] == 16'd0) ? 16'd1 : i_s_tdata[39:24];

    vpa_fit u_fit (
        .i_fit_mode (r_fit),
        .i_used     (rd_used),
        .i_len      (rd_len),
        .i_size     (r_size),
        .i_have     (r_have),
        .i_pick_len (r_plen),
        .o_fit      (fit)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = {5'd0, r_ofq, r_obase, r_oid, r_ostat};
    assign o_m_tlast   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= SC'(1);
            r_wcnt   <= '0;
            r_wi     <= '0;
            r_idx    <= '0;
            r_have   <= 1'b0;
            r_time   <= '0;
            r_fit    <= FIT_FIRST;
            r_base[0] <= '0;
            r_len[0]  <= MEM_SIZE_RESET;
            for (int j = 0; j < MAX_SEGMENTS; j++) begin
                r_used[j] <= 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        if (i_s_tuser == ACT_TICK) begin
                            r_time  <= r_time + 32'd1;
                            r_idx   <= '0;
                            r_state <= S_REL;
                        end else begin
                            r_id    <= i_s_tdata[7:0];
                            r_size  <= in_size;
                            r_run   <= in_run;
                            r_fromq <= 1'b0;
                            r_idx   <= '0;
                            r_have  <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_REL: begin
                    if (r_idx < r_cnt) begin
                        if (rd_used && (rd_rel == r_time)) begin
                            r_used[rd] <= 1'b0;
                        end
                        r_idx <= r_idx + SC'(1);
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    // r_acc and r_prevfree cache the segment just below r_idx.
                    if (r_idx == '0) begin
                        r_acc      <= rd_len;
                        r_prevfree <= !rd_used;
                        r_idx      <= SC'(1);
                    end else if (r_idx < r_cnt) begin
                        if (r_prevfree && !rd_used) begin
                            r_len[SI'(r_idx - SC'(1))] <= r_acc + rd_len;
                            r_acc <= r_acc + rd_len;
                            for (int j = 0; j < MAX_SEGMENTS - 1; j++) begin
                                if (SC'(j) >= r_idx) begin
                                    r_base[j] <= r_base[j+1];
                                    r_len[j]  <= r_len[j+1];
                                    r_own[j]  <= r_own[j+1];
                                    r_used[j] <= r_used[j+1];
                                    r_rel[j]  <= r_rel[j+1];
                                end
                            end
                            r_cnt <= r_cnt - SC'(1);
                        end else begin
                            r_acc      <= rd_len;
                            r_prevfree <= !rd_used;
                            r_idx      <= r_idx + SC'(1);
                        end
                    end else begin
                        r_wi    <= '0;
                        r_state <= S_QSCAN;
                    end
                end
                S_QSCAN: begin
                    if (r_wi < r_wcnt) begin
                        r_id    <= r_wid[wrd];
                        r_size  <= r_wsz[wrd];
                        r_run   <= r_wrun[wrd];
                        r_fromq <= 1'b1;
                        r_idx   <= '0;
                        r_have  <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_ovalid <= 1'b1;
                        r_ostat  <= ST_TICK;
                        r_oid    <= '0;
                        r_obase  <= '0;
                        r_ofq    <= 1'b0;
                        r_olast  <= 1'b1;
                        r_ret    <= S_IDLE;
                        r_state  <= S_OUT;
                    end
                end
                S_SCAN: begin
                    if (fit.take) begin
                        r_pick <= rd;
                        r_plen <= rd_len;
                        r_have <= 1'b1;
                    end
                    if (fit.stop || (r_idx + SC'(1) >= r_cnt)) begin
                        // Leave the pointer on the chosen hole.
                        r_idx   <= fit.take ? r_idx : SC'(r_pick);
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx <= r_idx + SC'(1);
                    end
                end
                S_DECIDE: begin
                    if (!r_have || ((left != 16'd0) && (r_cnt >= SC'(MAX_SEGMENTS)))) begin
                        if (r_fromq) begin
                            r_wi    <= r_wi + WC'(1);
                            r_state <= S_QSCAN;
                        end else begin
                            if (!r_have && (r_wcnt < WC'(WAIT_DEPTH))) begin
                                r_wid[r_wcnt[WI-1:0]]  <= r_id;
                                r_wsz[r_wcnt[WI-1:0]]  <= r_size;
                                r_wrun[r_wcnt[WI-1:0]] <= r_run;
                                r_wcnt  <= r_wcnt + WC'(1);
                                r_ostat <= ST_QUEUED;
                            end else begin
                                r_ostat <= ST_REJECT;
                            end
                            r_ovalid <= 1'b1;
                            r_oid    <= r_id;
                            r_obase  <= '0;
                            r_ofq    <= 1'b0;
                            r_olast  <= 1'b1;
                            r_ret    <= S_IDLE;
                            r_state  <= S_OUT;
                        end
                    end else begin
                        if (left != 16'd0) begin
                            for (int j = 1; j < MAX_SEGMENTS; j++) begin
                                if (SC'(j) > r_idx + SC'(1)) begin
                                    r_base[j] <= r_base[j-1];
                                    r_len[j]  <= r_len[j-1];
                                    r_own[j]  <= r_own[j-1];
                                    r_used[j] <= r_used[j-1];
                                    r_rel[j]  <= r_rel[j-1];
                                end
                            end
                            r_base[SI'(r_idx + SC'(1))] <= n_split_base;
                            r_len[SI'(r_idx + SC'(1))]  <= left;
                            r_own[SI'(r_idx + SC'(1))]  <= '0;
                            r_used[SI'(r_idx + SC'(1))] <= 1'b0;
                            r_rel[SI'(r_idx + SC'(1))]  <= '0;
                            r_cnt <= r_cnt + SC'(1);
                        end
                        r_len[rd]  <= r_size;
                        r_own[rd]  <= r_id;
                        r_used[rd] <= 1'b1;
                        r_rel[rd]  <= r_time + 32'(r_run);
                        if (r_fromq) begin
                            for (int j = 0; j < WAIT_DEPTH - 1; j++) begin
                                if (WC'(j) >= r_wi) begin
                                    r_wid[j]  <= r_wid[j+1];
                                    r_wsz[j]  <= r_wsz[j+1];
                                    r_wrun[j] <= r_wrun[j+1];
                                end
                            end
                            r_wcnt <= r_wcnt - WC'(1);
                            r_ret  <= S_QSCAN;
                        end else begin
                            r_ret <= S_IDLE;
                        end
                        r_ovalid <= 1'b1;
                        r_ostat  <= ST_GRANT;
                        r_oid    <= r_id;
                        r_obase  <= base_wide[15:0];
                        r_ofq    <= r_fromq;
                        r_olast  <= !r_fromq;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Configuration arrives only while the block is idle.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MEM_SIZE: begin
                        r_cnt     <= SC'(1);
                        r_base[0] <= '0;
                        r_len[0]  <= i_cfg_data;
                        r_used[0] <= 1'b0;
                    end
                    REG_FIT_MODE: begin
                        r_fit <= i_cfg_data[1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // The table always holds between one and MAX_SEGMENTS segments.
    a_seg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && (r_cnt <= SC'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    // The wait queue never overfills.
    a_wait_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= WC'(WAIT_DEPTH))
        else $error("wait queue overfilled");

    // No new word is taken while a result is pending.
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while a result is pending");

    // A tick-done result always closes its run.
    a_tick_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_ostat == ST_TICK)) |-> o_m_tlast)
        else $error("tick result without last");

endmodule
